// ----- design/hpes_pkg.sv -----
// Shared types, command codes and the constant pulse pattern table of the
// haptic pulse envelope sequencer. No dependencies.
package hpes_pkg;

  localparam int LEVEL_W   = 8;
  localparam int ELAPSED_W = 10;
  localparam int PROD_W    = LEVEL_W + ELAPSED_W;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 10'd1023;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [2:0] BEH_INVALID   = 3'd7;
  localparam logic [2:0] BEH_LAST_UP   = 3'd3;
  localparam logic [2:0] BEH_DOWN_BASE = 3'd3;

  localparam logic [0:0] REG_SPIN_FLOOR  = 1'd0;
  localparam logic [0:0] REG_BRAKE_LEVEL = 1'd1;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_RAMP_UP   = 6'b000010,
    ST_HOLD      = 6'b000100,
    ST_RAMP_DOWN = 6'b001000,
    ST_BRAKE     = 6'b010000,
    ST_GAP       = 6'b100000
  } stage_t;

  typedef struct packed {
    logic [2:0]                    count;
    logic [ELAPSED_W-1:0]          up_ms;
    logic [ELAPSED_W-1:0]          hold_ms;
    logic [ELAPSED_W-1:0]          down_ms;
    logic [ELAPSED_W-1:0]          brake_ms;
    logic [ELAPSED_W-1:0]          gap_ms;
    logic [7:0][LEVEL_W-1:0]       level;
  } shape_t;

  function automatic shape_t shape_of(input logic [1:0] rate);
    shape_t s;
    unique case (rate)
      2'd0: s = '{count: 3'd1, up_ms: 10'd100, hold_ms: 10'd400, down_ms: 10'd500,
                  brake_ms: 10'd0, gap_ms: 10'd0,
                  level: {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd190}};
      2'd1: s = '{count: 3'd2, up_ms: 10'd200, hold_ms: 10'd300, down_ms: 10'd200,
                  brake_ms: 10'd0, gap_ms: 10'd300,
                  level: {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd170}};
      2'd2: s = '{count: 3'd3, up_ms: 10'd200, hold_ms: 10'd400, down_ms: 10'd0,
                  brake_ms: 10'd30, gap_ms: 10'd260,
                  level: {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd200, 8'd140}};
      2'd3: s = '{count: 3'd4, up_ms: 10'd0, hold_ms: 10'd350, down_ms: 10'd0,
                  brake_ms: 10'd30, gap_ms: 10'd180,
                  level: {8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd225, 8'd185, 8'd145}};
    endcase
    return s;
  endfunction

endpackage

// ----- design/haptic_pulse_envelope_sequencer_unit.sv -----
// Haptic pulse envelope sequencer: stage sequencer around one shared
// multiply and divide unit. Depends on hpes_pkg and hpes_muldiv.
// Flow: stop, idle tick and rejected start go from idle to the done state and
// the output register; an accepted start passes the start state first; a
// playing tick visits the step state once per stage it passes (at most
// STEP_GUARD stages) and waits in the divide state when a ramp divide runs.
// One beat at a time: a new command is taken only in the idle state.
// Reset (synchronous): idle, nothing playing, both held levels 0, spin floor 60,
// brake_level 255.
module haptic_pulse_envelope_sequencer_unit #(
  parameter int STEP_GUARD = 8,
  parameter int MAX_PULSES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [2:0] behavior,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] fwd_level,
  output logic [7:0] rev_level,
  output logic       busy_res,
  output logic       accepted,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int CW = $clog2(MAX_PULSES + 1);
  localparam int GW = $clog2(STEP_GUARD + 1);
  localparam int LW = hpes_pkg::LEVEL_W;
  localparam int EW = hpes_pkg::ELAPSED_W;

  typedef enum logic [4:0] {
    C_IDLE  = 5'b00001,
    C_START = 5'b00010,
    C_STEP  = 5'b00100,
    C_DIV   = 5'b01000,
    C_DONE  = 5'b10000
  } ctl_t;

  ctl_t                 ctl;
  hpes_pkg::stage_t     stage;
  logic [1:0]           pattern_rate;
  logic                 going_up;
  logic [CW-1:0]        pulse_count_done;
  logic [LW-1:0]        target_level;
  logic [EW-1:0]        stage_elapsed;
  logic                 playing;
  logic [LW-1:0]        fwd_hold;
  logic [LW-1:0]        rev_hold;
  logic [GW-1:0]        guard;
  logic                 acc;
  logic [LW-1:0]        spin_floor;
  logic [LW-1:0]        brake_level;

  hpes_pkg::shape_t     sh;
  logic [CW-1:0]        n_pulses;
  logic                 pulses_left;
  logic [CW-1:0]        idx;
  logic [2:0]           idx_wide;
  logic [LW-1:0]        np_level;
  logic                 up_end, hold_end, down_end, brake_end, gap_end;
  logic                 step_live;
  logic                 md_start;
  logic                 md_done;
  logic [EW-1:0]        md_divisor;
  logic [LW-1:0]        md_quot;
  logic                 in_beat;
  logic                 start_ok;
  logic                 out_load;

  function automatic logic [LW-1:0] clamp_level(input logic [LW-1:0] v,
                                                input logic [LW-1:0] floor_v);
    logic [LW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v < floor_v) begin
      r = floor_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign sh          = hpes_pkg::shape_of(pattern_rate);
  assign n_pulses    = (int'(sh.count) < MAX_PULSES) ? CW'(sh.count) : CW'(MAX_PULSES);
  assign pulses_left = (pulse_count_done < n_pulses);
  assign idx         = going_up ? pulse_count_done
                                : (n_pulses - CW'(1) - pulse_count_done);
  assign idx_wide    = 3'(idx);
  assign np_level    = sh.level[idx_wide];

  assign up_end    = (sh.up_ms == '0)    || (stage_elapsed >= sh.up_ms);
  assign hold_end  = (sh.hold_ms == '0)  || (stage_elapsed >= sh.hold_ms);
  assign down_end  = (sh.down_ms == '0)  || (stage_elapsed >= sh.down_ms);
  assign brake_end = (sh.brake_ms == '0) || (stage_elapsed >= sh.brake_ms);
  assign gap_end   = (sh.gap_ms == '0)   || (stage_elapsed >= sh.gap_ms);

  assign step_live  = (ctl == C_STEP) && playing && (guard != GW'(STEP_GUARD));
  assign md_start   = step_live &&
                      (((stage == hpes_pkg::ST_RAMP_UP) && !up_end) ||
                       ((stage == hpes_pkg::ST_RAMP_DOWN) && !down_end));
  assign md_divisor = (stage == hpes_pkg::ST_RAMP_UP) ? sh.up_ms : sh.down_ms;

  assign in_ready = (ctl == C_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign start_ok = (behavior != hpes_pkg::BEH_INVALID) && !playing;
  assign out_load = (ctl == C_DONE) && (!out_valid || out_ready);

  hpes_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (md_start),
    .mult_a   (target_level),
    .mult_b   (stage_elapsed),
    .divisor  (md_divisor),
    .done     (md_done),
    .quotient (md_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spin_floor  <= 8'd60;
      brake_level <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpes_pkg::REG_SPIN_FLOOR:  spin_floor  <= cfg_data;
        hpes_pkg::REG_BRAKE_LEVEL: brake_level <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl              <= C_IDLE;
      stage            <= hpes_pkg::ST_IDLE;
      pattern_rate     <= '0;
      going_up         <= 1'b1;
      pulse_count_done <= '0;
      target_level     <= '0;
      stage_elapsed    <= '0;
      playing          <= 1'b0;
      fwd_hold         <= '0;
      rev_hold         <= '0;
      guard            <= '0;
      acc              <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctl)
        C_IDLE: begin
          if (in_beat) begin
            acc   <= (cmd == hpes_pkg::CMD_START) && start_ok;
            guard <= '0;
            unique case (cmd)
              hpes_pkg::CMD_TICK: begin
                if (playing) begin
                  if (stage_elapsed < hpes_pkg::ELAPSED_MAX) begin
                    stage_elapsed <= stage_elapsed + EW'(1);
                  end
                  ctl <= C_STEP;
                end else begin
                  ctl <= C_DONE;
                end
              end
              hpes_pkg::CMD_START: begin
                if (start_ok) begin
                  if (behavior <= hpes_pkg::BEH_LAST_UP) begin
                    pattern_rate <= behavior[1:0];
                    going_up     <= 1'b1;
                  end else begin
                    pattern_rate <= 2'(behavior - hpes_pkg::BEH_DOWN_BASE);
                    going_up     <= 1'b0;
                  end
                  pulse_count_done <= '0;
                  playing          <= 1'b1;
                  ctl              <= C_START;
                end else begin
                  ctl <= C_DONE;
                end
              end
              hpes_pkg::CMD_STOP: begin
                fwd_hold <= '0;
                rev_hold <= '0;
                playing  <= 1'b0;
                stage    <= hpes_pkg::ST_IDLE;
                ctl      <= C_DONE;
              end
              default: begin
                // An unused command code just repeats the held levels.
                ctl <= C_DONE;
              end
            endcase
          end
        end
        C_START: begin
          if (!pulses_left) begin
            fwd_hold <= '0;
            rev_hold <= '0;
            playing  <= 1'b0;
            stage    <= hpes_pkg::ST_IDLE;
          end else begin
            target_level     <= clamp_level(np_level, spin_floor);
            pulse_count_done <= pulse_count_done + CW'(1);
            fwd_hold         <= '0;
            rev_hold         <= '0;
            stage            <= hpes_pkg::ST_RAMP_UP;
            stage_elapsed    <= '0;
          end
          ctl <= C_DONE;
        end
        C_STEP: begin
          if (!step_live) begin
            ctl <= C_DONE;
          end else begin
            guard <= guard + GW'(1);
            unique case (stage)
              hpes_pkg::ST_RAMP_UP: begin
                if (up_end) begin
                  fwd_hold      <= clamp_level(target_level, spin_floor);
                  rev_hold      <= '0;
                  stage         <= hpes_pkg::ST_HOLD;
                  stage_elapsed <= '0;
                end else begin
                  ctl <= C_DIV;
                end
              end
              hpes_pkg::ST_HOLD: begin
                fwd_hold <= clamp_level(target_level, spin_floor);
                rev_hold <= '0;
                if (hold_end) begin
                  stage         <= hpes_pkg::ST_RAMP_DOWN;
                  stage_elapsed <= '0;
                end else begin
                  ctl <= C_DONE;
                end
              end
              hpes_pkg::ST_RAMP_DOWN: begin
                if (down_end) begin
                  fwd_hold      <= '0;
                  rev_hold      <= '0;
                  stage         <= hpes_pkg::ST_BRAKE;
                  stage_elapsed <= '0;
                end else begin
                  ctl <= C_DIV;
                end
              end
              hpes_pkg::ST_BRAKE: begin
                if (brake_end) begin
                  fwd_hold      <= '0;
                  rev_hold      <= '0;
                  stage         <= hpes_pkg::ST_GAP;
                  stage_elapsed <= '0;
                end else begin
                  fwd_hold <= '0;
                  rev_hold <= brake_level;
                  ctl      <= C_DONE;
                end
              end
              hpes_pkg::ST_GAP: begin
                if (!pulses_left) begin
                  fwd_hold <= '0;
                  rev_hold <= '0;
                  playing  <= 1'b0;
                  stage    <= hpes_pkg::ST_IDLE;
                end else if (gap_end) begin
                  target_level     <= clamp_level(np_level, spin_floor);
                  pulse_count_done <= pulse_count_done + CW'(1);
                  fwd_hold         <= '0;
                  rev_hold         <= '0;
                  stage            <= hpes_pkg::ST_RAMP_UP;
                  stage_elapsed    <= '0;
                end else begin
                  ctl <= C_DONE;
                end
              end
              default: begin
                // A playing pattern sitting in the idle stage ends here.
                fwd_hold <= '0;
                rev_hold <= '0;
                playing  <= 1'b0;
                stage    <= hpes_pkg::ST_IDLE;
              end
            endcase
          end
        end
        C_DIV: begin
          if (md_done) begin
            rev_hold <= '0;
            if (stage == hpes_pkg::ST_RAMP_UP) begin
              fwd_hold <= clamp_level(md_quot, spin_floor);
            end else begin
              // The quotient never exceeds the target, so this stays positive
              // or is zero for a zero target.
              fwd_hold <= clamp_level(target_level - md_quot, spin_floor);
            end
            ctl <= C_DONE;
          end
        end
        C_DONE: begin
          if (out_load) begin
            ctl <= C_IDLE;
          end
        end
        default: ctl <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fwd_level <= fwd_hold;
      rev_level <= rev_hold;
      busy_res  <= playing;
      accepted  <= acc;
    end
  end

endmodule

// ----- design/hpes_muldiv.sv -----
// Shared ramp arithmetic unit: a registered multiply on start, then a restoring
// divide that retires one quotient bit per cycle. Depends on hpes_pkg.
module hpes_muldiv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hpes_pkg::LEVEL_W-1:0]    mult_a,
  input  logic [hpes_pkg::ELAPSED_W-1:0]  mult_b,
  input  logic [hpes_pkg::ELAPSED_W-1:0]  divisor,
  output logic                            done,
  output logic [hpes_pkg::LEVEL_W-1:0]    quotient
);

  localparam int QW = hpes_pkg::LEVEL_W;
  localparam int PW = hpes_pkg::PROD_W;
  localparam int NW = $clog2(QW);

  logic [PW-1:0] rem;
  logic [PW-1:0] dsh;
  logic [NW-1:0] cnt;
  logic          busy;
  logic          fits;

  // The quotient is known to stay below 2**QW, so the divisor starts
  // aligned under the top quotient bit.
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(QW - 1);
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= PW'(mult_a) * PW'(mult_b);
      dsh      <= PW'({divisor, {(QW-1){1'b0}}});
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[QW-2:0], fits};
      dsh      <= dsh >> 1;
    end
  end

endmodule
